// ===== hw/rtl/dlhw_pkg.sv =====
// Shared types, register codes and reset constants for the hang watchdog.
package dlhw_pkg;

   // Event codes carried in the op field.
   typedef enum logic [2:0] {
      OP_TICK         = 3'd0,
      OP_YIELD        = 3'd1,
      OP_FRAME        = 3'd2,
      OP_RESUME_START = 3'd3,
      OP_RESUME_END   = 3'd4
   } op_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_HANG_LIMIT     = 2'd0,
      CSR_REPORT_SPACING = 2'd1,
      CSR_POLL_PERIOD    = 2'd2
   } csr_index_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned POLL_W      = 16;
   localparam int unsigned OP_W        = 3;
   localparam int unsigned THREAD_W    = 8;

   localparam logic [TIME_W-1:0]   HANG_LIMIT_RST     = 32'd3000;
   localparam logic [TIME_W-1:0]   REPORT_SPACING_RST = 32'd2000;
   localparam logic [POLL_W-1:0]   POLL_PERIOD_RST    = 16'd500;
   localparam logic [THREAD_W-1:0] NO_THREAD          = 8'hFF;

   // Current configuration as seen by the watchdog core.
   typedef struct packed {
      logic [TIME_W-1:0] hang_limit_ms;
      logic [TIME_W-1:0] report_spacing_ms;
      logic [POLL_W-1:0] poll_period_ms;
   } cfg_type;

   // One event held in the input stage.
   typedef struct packed {
      logic [OP_W-1:0]            op;
      logic signed [THREAD_W-1:0] thread_number;
   } item_type;

   // One hang report.
   typedef struct packed {
      logic [TIME_W-1:0]          frame_idle_ms;
      logic [TIME_W-1:0]          yield_idle_ms;
      logic signed [THREAD_W-1:0] running_thread;
      logic [TIME_W-1:0]          running_elapsed_ms;
      logic [TIME_W-1:0]          frames_seen;
      logic [TIME_W-1:0]          yields_seen;
   } report_type;

   // Handshake status between the pipeline stages.
   typedef struct packed {
      logic in_valid;
      logic out_free;
      logic advance;
   } flow_type;

endpackage

// ===== hw/rtl/dlhw_if.sv =====
// Channel interfaces for events, hang reports and configuration writes.
interface dlhw_req_if;
   import dlhw_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic signed [THREAD_W-1:0] thread_number;
   modport source (output valid, output op, output thread_number, input ready);
   modport sink (input valid, input op, input thread_number, output ready);
endinterface

interface dlhw_rsp_if;
   import dlhw_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [TIME_W-1:0]          frame_idle_ms;
   logic [TIME_W-1:0]          yield_idle_ms;
   logic signed [THREAD_W-1:0] running_thread;
   logic [TIME_W-1:0]          running_elapsed_ms;
   logic [TIME_W-1:0]          frames_seen;
   logic [TIME_W-1:0]          yields_seen;
   modport source (output valid, output frame_idle_ms, output yield_idle_ms,
                   output running_thread, output running_elapsed_ms,
                   output frames_seen, output yields_seen, input ready);
   modport sink (input valid, input frame_idle_ms, input yield_idle_ms,
                 input running_thread, input running_elapsed_ms,
                 input frames_seen, input yields_seen, output ready);
endinterface

interface dlhw_csr_if;
   import dlhw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dual_liveness_hang_watchdog_top.sv =====
// Top level of the dual liveness hang watchdog.
//
// Events (tick, yield, frame end, resume start, resume end) enter on req,
// one beat per cycle, and each event is applied in one pass of logic
// between the input register and the report register. A hang report
// for a tick beat passes the input register and then the report register
// before it leaves on rsp. Events move on one per cycle as long as the
// report register is empty or its beat is taken in the same cycle; a
// report that waits on rsp stops every event, so the input register holds
// at most one more beat and req stalls until the report is taken.
// Configuration writes on csr are always accepted and act on events that
// follow; change them only while no event is in flight.
module dual_liveness_hang_watchdog_top
   import dlhw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dlhw_req_if.sink     req,
   dlhw_rsp_if.source   rsp,
   dlhw_csr_if.sink     csr
);

   cfg_type    cfg;
   item_type   item;
   report_type report;
   flow_type   flow;
   logic       report_hit;

   dlhw_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   dlhw_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .advance  (flow.advance),
      .in_valid (flow.in_valid),
      .item     (item)
   );

   // An event moves on whenever the report slot can take its result.
   assign flow.advance = flow.in_valid && flow.out_free;

   dlhw_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .advance    (flow.advance),
      .item       (item),
      .report_hit (report_hit),
      .report     (report)
   );

   dlhw_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (report_hit),
      .report   (report),
      .out_free (flow.out_free),
      .rsp      (rsp)
   );

   // A report is produced only from a held event that is moving on.
   assert property (@(posedge clock) disable iff (reset)
      report_hit |-> (flow.in_valid && flow.out_free))
      else $error("report produced without a consumable event");

   // A produced report shows up on the result channel next cycle.
   assert property (@(posedge clock) disable iff (reset)
      report_hit |=> rsp.valid)
      else $error("report lost before the result channel");

   // A held event that cannot move on is still held next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (flow.in_valid && !flow.advance) |=> flow.in_valid)
      else $error("stalled event dropped from input register");

   // The input register cannot take a beat while a stalled event sits there.
   assert property (@(posedge clock) disable iff (reset)
      (flow.in_valid && !flow.out_free) |-> !req.ready)
      else $error("input accepted over a stalled event");

endmodule

// ===== hw/rtl/dlhw_csr.sv =====
// Configuration registers written through the csr channel.
module dlhw_csr
   import dlhw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dlhw_csr_if.sink     csr,
   output cfg_type      cfg
);

   logic [TIME_W-1:0] hang_limit_ff, hang_limit_in;
   logic [TIME_W-1:0] spacing_ff, spacing_in;
   logic [POLL_W-1:0] period_ff, period_in;

   // Writes are always taken.
   assign csr.ready = 1'b1;

   // Decode the register index; indexes past the list are dropped.
   always_comb begin
      hang_limit_in = hang_limit_ff;
      spacing_in    = spacing_ff;
      period_in     = period_ff;
      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_HANG_LIMIT:     hang_limit_in = csr.data;
            CSR_REPORT_SPACING: spacing_in    = csr.data;
            CSR_POLL_PERIOD:    period_in     = csr.data[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hang_limit_ff <= HANG_LIMIT_RST;
         spacing_ff    <= REPORT_SPACING_RST;
         period_ff     <= POLL_PERIOD_RST;
      end else begin
         hang_limit_ff <= hang_limit_in;
         spacing_ff    <= spacing_in;
         period_ff     <= period_in;
      end
   end

   assign cfg.hang_limit_ms     = hang_limit_ff;
   assign cfg.report_spacing_ms = spacing_ff;
   assign cfg.poll_period_ms    = period_ff;

endmodule

// ===== hw/rtl/dlhw_in_stage.sv =====
// Input register: holds one accepted event beat until the core consumes it.
module dlhw_in_stage
   import dlhw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dlhw_req_if.sink     req,
   input  logic         advance,
   output logic         in_valid,
   output item_type     item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // Room when empty or when the held event moves on this cycle.
   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in           = 1'b1;
         item_in.op         = req.op;
         item_in.thread_number = req.thread_number;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign in_valid = valid_ff;
   assign item     = item_ff;

endmodule

// ===== hw/rtl/dlhw_core.sv =====
// Watchdog state and the single-pass update applied to each event.
module dlhw_core
   import dlhw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         advance,
   input  item_type     item,
   output logic         report_hit,
   output report_type   report
);

   logic [TIME_W-1:0]   clock_ms_ff, clock_ms_in;
   logic [POLL_W-1:0]   poll_cnt_ff, poll_cnt_in;
   logic [TIME_W-1:0]   yield_total_ff, yield_total_in;
   logic [TIME_W-1:0]   frame_total_ff, frame_total_in;
   logic                yield_chg_ff, yield_chg_in;
   logic                frame_chg_ff, frame_chg_in;
   logic [TIME_W-1:0]   yield_time_ff, yield_time_in;
   logic [TIME_W-1:0]   frame_time_ff, frame_time_in;
   logic [TIME_W-1:0]   last_report_ff, last_report_in;
   logic [THREAD_W-1:0] active_ff, active_in;
   logic [TIME_W-1:0]   resume_time_ff, resume_time_in;
   logic                resume_valid_ff, resume_valid_in;

   logic [TIME_W-1:0]   now;
   logic [POLL_W-1:0]   poll_next;
   logic [TIME_W-1:0]   yield_gap;
   logic [TIME_W-1:0]   frame_gap;
   logic [TIME_W-1:0]   since_report;
   logic                hit;

   // Time after this tick, and the idle times measured against the
   // change stamps as they stand after the poll has refreshed them.
   // A counter that changed since the last poll is stamped with now.
   assign now          = clock_ms_ff + 1'b1;
   assign poll_next    = poll_cnt_ff + 1'b1;
   assign yield_gap    = yield_chg_ff ? '0 : (now - yield_time_ff);
   assign frame_gap    = frame_chg_ff ? '0 : (now - frame_time_ff);
   assign since_report = now - last_report_ff;

   // Next-state logic for one event.
   always_comb begin
      clock_ms_in     = clock_ms_ff;
      poll_cnt_in     = poll_cnt_ff;
      yield_total_in  = yield_total_ff;
      frame_total_in  = frame_total_ff;
      yield_chg_in    = yield_chg_ff;
      frame_chg_in    = frame_chg_ff;
      yield_time_in   = yield_time_ff;
      frame_time_in   = frame_time_ff;
      last_report_in  = last_report_ff;
      active_in       = active_ff;
      resume_time_in  = resume_time_ff;
      resume_valid_in = resume_valid_ff;
      hit             = 1'b0;
      case (op_type'(item.op))
         OP_TICK: begin
            clock_ms_in = now;
            poll_cnt_in = poll_next;
            if (poll_next >= cfg.poll_period_ms) begin
               // Poll: stamp changed counters, then check for a hang.
               poll_cnt_in  = '0;
               yield_chg_in = 1'b0;
               frame_chg_in = 1'b0;
               if (yield_chg_ff) begin
                  yield_time_in = now;
               end
               if (frame_chg_ff) begin
                  frame_time_in = now;
               end
               if ((frame_total_ff != '0) &&
                   (frame_gap > cfg.hang_limit_ms) &&
                   (yield_gap > cfg.hang_limit_ms) &&
                   (since_report >= cfg.report_spacing_ms)) begin
                  hit            = 1'b1;
                  last_report_in = now;
               end
            end
         end
         OP_YIELD: begin
            yield_total_in = yield_total_ff + 1'b1;
            yield_chg_in   = 1'b1;
         end
         OP_FRAME: begin
            frame_total_in = frame_total_ff + 1'b1;
            frame_chg_in   = 1'b1;
         end
         OP_RESUME_START: begin
            resume_time_in  = clock_ms_ff;
            active_in       = item.thread_number;
            resume_valid_in = 1'b1;
         end
         OP_RESUME_END: begin
            active_in       = NO_THREAD;
            resume_time_in  = '0;
            resume_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Report payload; elapsed time only for a valid non-negative thread.
   always_comb begin
      report.frame_idle_ms  = frame_gap;
      report.yield_idle_ms  = yield_gap;
      report.running_thread = active_ff;
      report.running_elapsed_ms =
         (resume_valid_ff && !active_ff[THREAD_W-1]) ? (now - resume_time_ff) : '0;
      report.frames_seen    = frame_total_ff;
      report.yields_seen    = yield_total_ff;
   end

   assign report_hit = advance && hit;

   // State registers advance only when the event moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff     <= '0;
         poll_cnt_ff     <= '0;
         yield_total_ff  <= '0;
         frame_total_ff  <= '0;
         yield_chg_ff    <= 1'b0;
         frame_chg_ff    <= 1'b0;
         yield_time_ff   <= '0;
         frame_time_ff   <= '0;
         last_report_ff  <= '0;
         active_ff       <= NO_THREAD;
         resume_time_ff  <= '0;
         resume_valid_ff <= 1'b0;
      end else if (advance) begin
         clock_ms_ff     <= clock_ms_in;
         poll_cnt_ff     <= poll_cnt_in;
         yield_total_ff  <= yield_total_in;
         frame_total_ff  <= frame_total_in;
         yield_chg_ff    <= yield_chg_in;
         frame_chg_ff    <= frame_chg_in;
         yield_time_ff   <= yield_time_in;
         frame_time_ff   <= frame_time_in;
         last_report_ff  <= last_report_in;
         active_ff       <= active_in;
         resume_time_ff  <= resume_time_in;
         resume_valid_ff <= resume_valid_in;
      end
   end

endmodule

// ===== hw/rtl/dlhw_out_reg.sv =====
// Result register: holds one hang report beat until the sink takes it.
module dlhw_out_reg
   import dlhw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  report_type   report,
   output logic         out_free,
   dlhw_rsp_if.source   rsp
);

   logic       valid_ff, valid_in;
   report_type data_ff, data_in;

   // The slot frees up when empty or when its beat leaves this cycle.
   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = report;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid              = valid_ff;
   assign rsp.frame_idle_ms      = data_ff.frame_idle_ms;
   assign rsp.yield_idle_ms      = data_ff.yield_idle_ms;
   assign rsp.running_thread     = data_ff.running_thread;
   assign rsp.running_elapsed_ms = data_ff.running_elapsed_ms;
   assign rsp.frames_seen        = data_ff.frames_seen;
   assign rsp.yields_seen        = data_ff.yields_seen;

endmodule
